// ===== design/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// AES-128 package
// Block type, substitution tables, GF(2^8) helpers and round functions.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int ROUND_KEY_COUNT = 11;
    localparam int ROUNDS          = ROUND_KEY_COUNT - 1;

    typedef logic [15:0][7:0] t_blk;

    typedef enum logic {
        CFG_KEY_HIGH = 1'b0,
        CFG_KEY_LOW  = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        KIND_ENC = 1'b0,
        KIND_DEC = 1'b1
    } t_kind;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    localparam logic [7:0] POLY = 8'h1b;

    function automatic logic [7:0] xtime(logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? POLY : 8'h00);
    endfunction

    // byte n of the block sits in element 15-n
    function automatic logic [7:0] get_b(t_blk s, int n);
        return s[15-n];
    endfunction

    function automatic t_blk enc_round(t_blk s, t_blk k, logic last);
        t_blk       t;
        t_blk       m;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[15-(c*4+r)] = SBOX[get_b(s, ((c + r) & 3) * 4 + r)];
            end
        end
        m = t;
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[15-(c*4)];
                a1 = t[15-(c*4+1)];
                a2 = t[15-(c*4+2)];
                a3 = t[15-(c*4+3)];
                m[15-(c*4)]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
                m[15-(c*4+1)] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
                m[15-(c*4+2)] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
                m[15-(c*4+3)] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
            end
        end
        return m ^ k;
    endfunction

    function automatic t_blk dec_round(t_blk s, t_blk k, logic last);
        t_blk       t;
        t_blk       m;
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[15-(c*4+r)] = INV_SBOX[get_b(s, ((c - r) & 3) * 4 + r)];
            end
        end
        t = t ^ k;
        m = t;
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                for (int j = 0; j < 4; j++) begin
                    a[j]  = t[15-(c*4+j)];
                    x2[j] = xtime(a[j]);
                    x4[j] = xtime(x2[j]);
                    x8[j] = xtime(x4[j]);
                    m9[j] = x8[j] ^ a[j];
                    mb[j] = x8[j] ^ x2[j] ^ a[j];
                    md[j] = x8[j] ^ x4[j] ^ a[j];
                    me[j] = x8[j] ^ x4[j] ^ x2[j];
                end
                for (int r = 0; r < 4; r++) begin
                    m[15-(c*4+r)] = me[r] ^ mb[(r+1)&3] ^ md[(r+2)&3] ^ m9[(r+3)&3];
                end
            end
        end
        return m;
    endfunction

    function automatic t_blk next_key(t_blk p, logic [7:0] rcon);
        logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
        w0 = p[15:12];
        w1 = p[11:8];
        w2 = p[7:4];
        w3 = p[3:0];
        t  = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        n0 = w0 ^ t;
        n1 = w1 ^ n0;
        n2 = w2 ^ n1;
        n3 = w3 ^ n2;
        return {n0, n1, n2, n3};
    endfunction

endpackage

// ===== design/aes128_block_cipher.sv =====
// ----------------------------------------------------------------------------
// AES-128 block cipher
// Pipelined AES-128 encrypt/decrypt with cached round keys.
// ----------------------------------------------------------------------------
// Input channel i_valid/o_ready carries one item: direction bit and a
// 128-bit block split into two 64-bit halves, byte 0 on top. Output channel
// o_valid/i_ready returns one 128-bit result per item, in order.
// The key lives in two registers written through i_cfg_we/i_cfg_idx/
// i_cfg_data. After each key write, and after reset, the round keys are
// expanded one per cycle into a key cache; o_ready stays low meanwhile.
// The datapath is eleven register stages, one per round plus the initial
// key addition. One item enters per cycle unless output stalls or keys
// are expanding. A stage holds its item while the next cannot take it,
// so a stalled receiver fills the pipeline back to front and nothing is
// lost; bubbles close up while output waits. Reset clears all valid bits.
// ----------------------------------------------------------------------------
module aes128_block_cipher
    import aes_pkg::*;
#(
    parameter int P_ROUND_KEY_COUNT = ROUND_KEY_COUNT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [63:0] i_data_high,
    input  logic [63:0] i_data_low,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_result_high,
    output logic [63:0] o_result_low
);

    localparam int LAST = P_ROUND_KEY_COUNT - 1;
    localparam int CW   = $clog2(P_ROUND_KEY_COUNT);

    logic [63:0]   r_key_high;
    logic [63:0]   r_key_low;
    t_blk          r_prev;
    logic [7:0]    r_rcon;
    logic [CW-1:0] r_kcnt;
    t_blk          r_rk [P_ROUND_KEY_COUNT];
    t_blk          r_rk_0;
    t_blk          n_rk;
    logic          busy;

    t_blk          r_st   [P_ROUND_KEY_COUNT];
    logic          r_kd   [P_ROUND_KEY_COUNT];
    logic          r_vld  [P_ROUND_KEY_COUNT];
    logic          rdy    [P_ROUND_KEY_COUNT];
    t_blk          n_st   [P_ROUND_KEY_COUNT];
    logic          in_vld [P_ROUND_KEY_COUNT];
    logic          in_kd  [P_ROUND_KEY_COUNT];

    assign busy = (r_kcnt != '0);
    assign n_rk = next_key(r_prev, r_rcon);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_prev     <= '0;
            r_rcon     <= 8'h01;
            r_kcnt     <= CW'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_KEY_HIGH: begin
                    r_key_high <= i_cfg_data;
                    r_prev     <= {i_cfg_data, r_key_low};
                end
                CFG_KEY_LOW: begin
                    r_key_low <= i_cfg_data;
                    r_prev    <= {r_key_high, i_cfg_data};
                end
                default: ;
            endcase
            r_rcon <= 8'h01;
            r_kcnt <= CW'(1);
        end else if (busy) begin
            r_prev <= n_rk;
            r_rcon <= xtime(r_rcon);
            r_kcnt <= (r_kcnt == CW'(LAST)) ? '0 : r_kcnt + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (busy) begin
            r_rk[r_kcnt] <= n_rk;
        end
    end

    always_comb begin
        r_rk_0 = {r_key_high, r_key_low};
    end

    always_comb begin
        rdy[LAST] = !r_vld[LAST] || i_ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign o_ready = rdy[0] && !busy;

    always_comb begin
        in_vld[0] = i_valid && o_ready;
        in_kd[0]  = i_kind;
        n_st[0]   = {i_data_high, i_data_low} ^
                    ((t_kind'(i_kind) == KIND_DEC) ? r_rk[LAST] : r_rk_0);
    end

    genvar g;
    generate
        for (g = 1; g < P_ROUND_KEY_COUNT; g++) begin : g_round
            t_blk key_e;
            t_blk key_d;
            if (g == LAST) begin : g_ke
                assign key_d = r_rk_0;
            end else begin : g_kd
                assign key_d = r_rk[LAST-g];
            end
            assign key_e = r_rk[g];
            always_comb begin
                in_vld[g] = r_vld[g-1];
                in_kd[g]  = r_kd[g-1];
                n_st[g]   = (t_kind'(r_kd[g-1]) == KIND_DEC)
                          ? dec_round(r_st[g-1], key_d, (g == LAST))
                          : enc_round(r_st[g-1], key_e, (g == LAST));
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < P_ROUND_KEY_COUNT; k++) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (rdy[k]) begin
                r_vld[k] <= in_vld[k];
            end
            if (rdy[k]) begin
                r_st[k] <= n_st[k];
                r_kd[k] <= in_kd[k];
            end
        end
    end

    assign o_valid       = r_vld[LAST];
    assign o_result_high = r_st[LAST][15:8];
    assign o_result_low  = r_st[LAST][7:0];

endmodule

// ===== design/aes128_block_cipher_checker.sv =====
// ----------------------------------------------------------------------------
// AES-128 port checker
// Port-level properties of the cipher, bound to the top level.
// ----------------------------------------------------------------------------
module aes128_block_cipher_checker
    import aes_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [63:0] o_result_high,
    input logic [63:0] o_result_low
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_high) && $stable(o_result_low))
        else $error("result changed while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_ready)
        else $error("output or input open right after reset");

    a_cfg_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !o_ready)
        else $error("input open during key expansion");

    a_cfg_block2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> ##8 !o_ready)
        else $error("key expansion ended early");

endmodule

bind aes128_block_cipher aes128_block_cipher_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_we      (i_cfg_we),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_result_high (o_result_high),
    .o_result_low  (o_result_low)
);
